// File: sv/pmid_pkg.sv
// shared types and constants of the periodic minimum image distance block
package pmid_pkg;

  // default configuration
  localparam int DIMS_DEF       = 3;
  localparam int COORD_BITS_DEF = 20;

  // fixed field widths
  localparam int SIDE_BITS    = 20;
  localparam int DIST_BITS    = 40;
  localparam int CFG_IDX_BITS = 2;
  localparam int NUM_SIDES    = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_Z = 2'd2;

  // side value after reset
  localparam logic [SIDE_BITS-1:0] SIDE_RESET = '1;

  // control that travels alongside each item
  typedef struct packed {
    logic valid;
    logic func;
    logic oob;
  } pmid_ctl_t;

  // one result beat
  typedef struct packed {
    logic [DIST_BITS-1:0] dist_value;
    logic                 out_of_box;
  } pmid_res_t;

endpackage

// File: sv/pmid_ifs.sv
// channel interfaces: particle pair input, distance output, configuration writes
interface pmid_pair_if #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [COORD_BITS-1:0] first_x;
  logic [COORD_BITS-1:0] first_y;
  logic [COORD_BITS-1:0] first_z;
  logic [COORD_BITS-1:0] second_x;
  logic [COORD_BITS-1:0] second_y;
  logic [COORD_BITS-1:0] second_z;

  modport source (
    output valid, func, first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, func, first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

interface pmid_dist_if;
  logic                           valid;
  logic                           ready;
  logic [pmid_pkg::DIST_BITS-1:0] dist_value;
  logic                           out_of_box;

  modport source (output valid, dist_value, out_of_box, input ready);
  modport sink (input valid, dist_value, out_of_box, output ready);
endinterface

interface pmid_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pmid_pkg::CFG_IDX_BITS-1:0] index;
  logic [pmid_pkg::SIDE_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/pmid_lane.sv
// one dimension: range check, absolute difference, periodic fold and square
module pmid_lane #(
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    adv,
  input  logic [COORD_BITS-1:0]   side,
  input  logic [COORD_BITS-1:0]   p,
  input  logic [COORD_BITS-1:0]   q,
  output logic [2*COORD_BITS-1:0] sq,
  output logic                    oob
);

  logic [COORD_BITS-1:0] mag1;
  logic                  oob1;
  logic [COORD_BITS-1:0] mag2;
  logic                  oob2;
  logic                  fold;

  // stage 1: coordinate range check and magnitude of the difference
  always_ff @(posedge clk) begin
    if (adv) begin
      oob1 <= (p >= side) || (q >= side);
      mag1 <= (p >= q) ? (p - q) : (q - p);
    end
  end

  // stage 2: take the nearer image when twice the magnitude exceeds the side
  assign fold = {mag1, 1'b0} > {1'b0, side};

  always_ff @(posedge clk) begin
    if (adv) begin
      oob2 <= oob1;
      mag2 <= fold ? (side - mag1) : mag1;
    end
  end

  // stage 3: square
  always_ff @(posedge clk) begin
    if (adv) begin
      oob <= oob2;
      sq  <= (2*COORD_BITS)'(mag2) * (2*COORD_BITS)'(mag2);
    end
  end

endmodule

// File: sv/pmid_root_cell.sv
// one cell of the square root chain: settles one root bit from two radicand bits
module pmid_root_cell #(
  parameter int ROOT_W = pmid_pkg::COORD_BITS_DEF + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  pmid_pkg::pmid_ctl_t      ctl_in,
  input  logic [2*ROOT_W-1:0]      rad_in,
  input  logic [ROOT_W-1:0]        q_in,
  input  logic [ROOT_W+1:0]        rem_in,
  output pmid_pkg::pmid_ctl_t      ctl_out,
  output logic [2*ROOT_W-1:0]      rad_out,
  output logic [ROOT_W-1:0]        q_out,
  output logic [ROOT_W+1:0]        rem_out
);

  localparam int SUM_W = 2*ROOT_W;
  localparam int RW    = ROOT_W + 2;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;

  // bring down the next two radicand bits and try the next root bit
  assign rem_sh = {rem_in[RW-3:0], rad_in[SUM_W-1 -: 2]};
  assign trial  = {q_in, 2'b01};
  assign ge     = rem_sh >= trial;

  // control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  // partial root and remainder; radicand rotates so the full sum comes out the end
  always_ff @(posedge clk) begin
    if (adv) begin
      rad_out <= {rad_in[SUM_W-3:0], rad_in[SUM_W-1 -: 2]};
      q_out   <= {q_in[ROOT_W-2:0], ge};
      rem_out <= ge ? (rem_sh - trial) : rem_sh;
    end
  end

endmodule

// File: sv/periodic_min_image_distance.sv
// throughput: one pair per cycle while the skid entry is empty; three lane stages, one
// sum stage and one root cell per root bit (COORD_BITS + 1 cells) form the pipeline,
// then a two-entry output buffer
// pair ready drops only while both output buffer entries are full
// synchronous reset empties the pipeline and buffer and sets every side to its maximum
module periodic_min_image_distance #(
  parameter int DIMS       = pmid_pkg::DIMS_DEF,
  parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  pmid_pair_if.sink   pair,
  pmid_dist_if.source result,
  pmid_cfg_if.sink    cfg
);

  localparam int ROOT_W  = COORD_BITS + 1;
  localparam int SUM_W   = 2*ROOT_W;
  localparam int RW      = ROOT_W + 2;
  localparam int SQ_W    = 2*COORD_BITS;
  localparam int FRONT_N = 4;

  logic [pmid_pkg::SIDE_BITS-1:0] side_reg [pmid_pkg::NUM_SIDES];
  logic [COORD_BITS-1:0]          side_eff [pmid_pkg::NUM_SIDES];
  logic [COORD_BITS-1:0]          p_all    [pmid_pkg::NUM_SIDES];
  logic [COORD_BITS-1:0]          q_all    [pmid_pkg::NUM_SIDES];
  logic [SQ_W-1:0]                sq       [DIMS];
  logic [DIMS-1:0]                lane_oob;

  pmid_pkg::pmid_ctl_t ctl_s [FRONT_N];
  logic [SUM_W-1:0]    sum_s4;
  logic [SUM_W-1:0]    sum_next;

  pmid_pkg::pmid_ctl_t ctl_c [ROOT_W+1];
  logic [SUM_W-1:0]    rad_c [ROOT_W+1];
  logic [ROOT_W-1:0]   q_c   [ROOT_W+1];
  logic [RW-1:0]       rem_c [ROOT_W+1];

  logic                adv;
  logic                push;
  logic                pop;
  logic                o_free;
  pmid_pkg::pmid_res_t push_res;
  pmid_pkg::pmid_res_t o_res;
  pmid_pkg::pmid_res_t s_res;
  logic                o_valid;
  logic                s_valid;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pmid_pkg::NUM_SIDES; i++) begin
        side_reg[i] <= pmid_pkg::SIDE_RESET;
      end
    end else if (cfg.valid) begin
      case (cfg.index)
        pmid_pkg::REG_SIDE_X: side_reg[0] <= cfg.data;
        pmid_pkg::REG_SIDE_Y: side_reg[1] <= cfg.data;
        pmid_pkg::REG_SIDE_Z: side_reg[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  // coordinates and sides taken at coordinate width
  always_comb begin
    for (int i = 0; i < pmid_pkg::NUM_SIDES; i++) begin
      side_eff[i] = COORD_BITS'(side_reg[i]);
    end
    p_all[0] = pair.first_x;
    p_all[1] = pair.first_y;
    p_all[2] = pair.first_z;
    q_all[0] = pair.second_x;
    q_all[1] = pair.second_y;
    q_all[2] = pair.second_z;
  end

  // whole pipeline moves while the output buffer has a free entry
  assign adv        = !s_valid;
  assign pair.ready = adv;

  // per-dimension lanes
  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    pmid_lane #(.COORD_BITS(COORD_BITS)) u_lane (
      .clk  (clk),
      .adv  (adv),
      .side (side_eff[d]),
      .p    (p_all[d]),
      .q    (q_all[d]),
      .sq   (sq[d]),
      .oob  (lane_oob[d])
    );
  end

  // control alongside the lane stages, then the sum stage
  always_comb begin
    sum_next = '0;
    for (int d = 0; d < DIMS; d++) begin
      sum_next = sum_next + SUM_W'(sq[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRONT_N; i++) begin
        ctl_s[i] <= '0;
      end
    end else if (adv) begin
      ctl_s[0].valid <= pair.valid;
      ctl_s[0].func  <= pair.func;
      ctl_s[0].oob   <= 1'b0;
      ctl_s[1]       <= ctl_s[0];
      ctl_s[2]       <= ctl_s[1];
      ctl_s[3].valid <= ctl_s[2].valid;
      ctl_s[3].func  <= ctl_s[2].func;
      ctl_s[3].oob   <= |lane_oob;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_s4 <= sum_next;
    end
  end

  // square root chain
  assign ctl_c[0] = ctl_s[FRONT_N-1];
  assign rad_c[0] = sum_s4;
  assign q_c[0]   = '0;
  assign rem_c[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    pmid_root_cell #(.ROOT_W(ROOT_W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .ctl_in  (ctl_c[k]),
      .rad_in  (rad_c[k]),
      .q_in    (q_c[k]),
      .rem_in  (rem_c[k]),
      .ctl_out (ctl_c[k+1]),
      .rad_out (rad_c[k+1]),
      .q_out   (q_c[k+1]),
      .rem_out (rem_c[k+1])
    );
  end

  // result selection; the rotated radicand is the sum again at the chain end
  assign push = ctl_c[ROOT_W].valid && adv;

  always_comb begin
    push_res.out_of_box = ctl_c[ROOT_W].oob;
    if (ctl_c[ROOT_W].oob) begin
      push_res.dist_value = '0;
    end else if (ctl_c[ROOT_W].func) begin
      push_res.dist_value = pmid_pkg::DIST_BITS'(q_c[ROOT_W]);
    end else begin
      push_res.dist_value = pmid_pkg::DIST_BITS'(rad_c[ROOT_W]);
    end
  end

  // two-entry output buffer: output register plus skid entry
  assign pop    = o_valid && result.ready;
  assign o_free = !o_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (o_free) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= push;
      end else begin
        o_valid <= push;
      end
    end else if (push) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      if (s_valid) begin
        o_res <= s_res;
        s_res <= push_res;
      end else begin
        o_res <= push_res;
      end
    end else if (push) begin
      s_res <= push_res;
    end
  end

  assign result.valid      = o_valid;
  assign result.dist_value = o_res.dist_value;
  assign result.out_of_box = o_res.out_of_box;

`ifndef ASSERT_OFF
  // skid entry only holds a beat behind a waiting output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid entry full while output register empty");

  // skid entry fills only when the output beat was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(s_valid) |-> $past(o_valid && !result.ready))
    else $error("skid entry filled without a stalled output beat");

  // out of box results carry a zero distance
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.out_of_box) |-> (result.dist_value == '0))
    else $error("out of box result with nonzero distance");

  // final root remainder stays within twice the root
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    ctl_c[ROOT_W].valid |-> (rem_c[ROOT_W] <= RW'({q_c[ROOT_W], 1'b0})))
    else $error("square root remainder out of bound");
`endif

endmodule

// File: bench/tb_periodic_min_image_distance.sv
// self-checking bench for the periodic minimum image distance block
`timescale 1ns / 100ps

module tb_periodic_min_image_distance;

  localparam int COORD_BITS   = pmid_pkg::COORD_BITS_DEF;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_AFTER   = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 200000;

  // index with no register behind it, writes there are dropped
  localparam logic [pmid_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam logic [COORD_BITS-1:0]             COORD_MAX  = '1;

  typedef struct packed {
    logic                       func;
    logic [2:0][COORD_BITS-1:0] first;
    logic [2:0][COORD_BITS-1:0] second;
  } pair_beat_t;

  logic clk;
  logic rst;

  pmid_pair_if #(.COORD_BITS(COORD_BITS)) pair_ch ();
  pmid_dist_if dist_ch ();
  pmid_cfg_if  cfg_ch ();

  periodic_min_image_distance u_top (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair_ch),
    .result (dist_ch),
    .cfg    (cfg_ch)
  );

  // bench copy of the box sides
  logic [pmid_pkg::SIDE_BITS-1:0] side_len [pmid_pkg::NUM_SIDES];

  pair_beat_t          pair_backlog_q [$];
  pmid_pkg::pmid_res_t expected_dist_q [$];
  pair_beat_t          pair_cur;
  pair_beat_t          pair_next;
  pmid_pkg::pmid_res_t dist_want;

  int pairs_queued;
  int pairs_accepted;
  int error_count;
  int src_wait;
  int sink_wait;
  int next_wait;
  int hold_left;
  bit hold_done;
  bit steady_src;
  bit steady_sink;
  int cycle_count;

  // floor square root, one result bit per step from the top
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 21; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // minimum image distance of one pair under the current sides
  function automatic pmid_pkg::pmid_res_t predict_distance(input pair_beat_t b);
    pmid_pkg::pmid_res_t res;
    logic [63:0]         sum;
    logic [63:0]         mag;
    logic [63:0]         span;
    logic [63:0]         p;
    logic [63:0]         q;
    logic                outside;
    sum = '0;
    outside = 1'b0;
    for (int d = 0; d < pmid_pkg::DIMS_DEF; d++) begin
      span = 64'(side_len[d]);
      p = 64'(b.first[d]);
      q = 64'(b.second[d]);
      if (p >= span || q >= span) begin
        outside = 1'b1;
      end else begin
        mag = (p >= q) ? p - q : q - p;
        // fold across the boundary when the gap exceeds half a side
        if (2 * mag > span) mag = span - mag;
        sum += mag * mag;
      end
    end
    res.out_of_box = outside;
    if (outside) res.dist_value = '0;
    else if (b.func) res.dist_value = pmid_pkg::DIST_BITS'(floor_root(sum));
    else res.dist_value = pmid_pkg::DIST_BITS'(sum);
    return res;
  endfunction

  function automatic pair_beat_t make_pair(
    input logic func,
    input int   fx, fy, fz,
    input int   sx, sy, sz
  );
    pair_beat_t b;
    b.func = func;
    b.first = {COORD_BITS'(fz), COORD_BITS'(fy), COORD_BITS'(fx)};
    b.second = {COORD_BITS'(sz), COORD_BITS'(sy), COORD_BITS'(sx)};
    return b;
  endfunction

  // mostly inside the box, some exactly on the side, some anywhere
  function automatic logic [COORD_BITS-1:0] pick_coord(
    input logic [pmid_pkg::SIDE_BITS-1:0] span
  );
    int unsigned r;
    r = $urandom_range(0, 99);
    if (span != 0 && r < 88) return COORD_BITS'($urandom_range(0, span - 1));
    if (r < 94) return COORD_BITS'(span);
    return COORD_BITS'($urandom_range(0, COORD_MAX));
  endfunction

  function automatic pair_beat_t random_pair(
    input logic [2:0][pmid_pkg::SIDE_BITS-1:0] box
  );
    pair_beat_t  b;
    longint      span;
    longint      f;
    int unsigned r;
    b.func = 1'($urandom_range(0, 1));
    for (int d = 0; d < pmid_pkg::NUM_SIDES; d++) begin
      span = longint'(box[d]);
      b.first[d] = pick_coord(box[d]);
      f = longint'(b.first[d]);
      r = $urandom_range(0, 99);
      // partners near half a side apart hit the fold and the tie
      if (r < 20 && span > 1 && f < span) begin
        b.second[d] = COORD_BITS'((f + span / 2 + span + $urandom_range(0, 2) - 1) % span);
      end else begin
        b.second[d] = pick_coord(box[d]);
      end
    end
    return b;
  endfunction

  task automatic queue_pair(input pair_beat_t b);
    pair_backlog_q = {pair_backlog_q, b};
    pairs_queued++;
  endtask

  // wait until every queued pair has been taken and its result seen
  task automatic wait_drained();
    do @(posedge clk);
    while (pairs_accepted != pairs_queued || expected_dist_q.size() != 0);
  endtask

  // write all three sides back to back, optionally also the unused index
  task automatic program_box(input logic [2:0][pmid_pkg::SIDE_BITS-1:0] box,
                             input bit with_spare);
    logic [pmid_pkg::CFG_IDX_BITS-1:0] idx_list [4];
    logic [pmid_pkg::SIDE_BITS-1:0]    val;
    int                                n;
    idx_list = '{pmid_pkg::REG_SIDE_X, pmid_pkg::REG_SIDE_Y, pmid_pkg::REG_SIDE_Z,
                 REG_UNUSED};
    n = with_spare ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      val = (idx_list[k] == REG_UNUSED) ? pmid_pkg::SIDE_BITS'($urandom()) : box[k];
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx_list[k];
      cfg_ch.data <= val;
      do @(posedge clk);
      while (!cfg_ch.ready);
      if (idx_list[k] != REG_UNUSED) side_len[idx_list[k]] = val;
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_periodic_min_image_distance: FAIL");
      $finish;
    end
  end

  // pair driver: one beat at a time from the backlog, random gaps between beats unless steady_src is set
  always @(posedge clk) begin
    if (rst) begin
      pair_ch.valid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (pair_ch.valid && pair_ch.ready) begin
        expected_dist_q = {expected_dist_q, predict_distance(pair_cur)};
        pairs_accepted <= pairs_accepted + 1;
      end
      if (!pair_ch.valid || pair_ch.ready) begin
        if (src_wait != 0 || pair_backlog_q.size() == 0) begin
          pair_ch.valid <= 1'b0;
          if (src_wait != 0) src_wait <= src_wait - 1;
        end else begin
          pair_next = pair_backlog_q.pop_front();
          pair_cur <= pair_next;
          pair_ch.valid <= 1'b1;
          pair_ch.func <= pair_next.func;
          pair_ch.first_x <= pair_next.first[0];
          pair_ch.first_y <= pair_next.first[1];
          pair_ch.first_z <= pair_next.first[2];
          pair_ch.second_x <= pair_next.second[0];
          pair_ch.second_y <= pair_next.second[1];
          pair_ch.second_z <= pair_next.second[2];
          src_wait <= steady_src ? 0 : $urandom_range(0, 6);
        end
      end
    end
  end

  // one long back-pressure stretch once traffic is flowing
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && pairs_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // distance monitor: compare each beat with the oldest prediction, random stalls unless steady_sink is set
  always @(posedge clk) begin
    if (rst) begin
      dist_ch.ready <= 1'b0;
      sink_wait <= 0;
    end else begin
      next_wait = sink_wait;
      if (dist_ch.valid && dist_ch.ready) begin
        if (expected_dist_q.size() == 0) begin
          if (error_count < MAX_REPORTS) begin
            $display("unexpected distance beat: dist_value=%0d out_of_box=%0b",
                     dist_ch.dist_value, dist_ch.out_of_box);
          end
          error_count++;
        end else begin
          dist_want = expected_dist_q.pop_front();
          if (dist_ch.dist_value !== dist_want.dist_value ||
              dist_ch.out_of_box !== dist_want.out_of_box) begin
            if (error_count < MAX_REPORTS) begin
              $display("distance mismatch: dist_value exp=%0d got=%0d, out_of_box exp=%0b got=%0b",
                       dist_want.dist_value, dist_ch.dist_value,
                       dist_want.out_of_box, dist_ch.out_of_box);
            end
            error_count++;
          end
        end
        next_wait = steady_sink ? 0 : $urandom_range(0, 6);
      end
      if (hold_left != 0) begin
        dist_ch.ready <= 1'b0;
        sink_wait <= next_wait;
      end else if (next_wait != 0) begin
        dist_ch.ready <= 1'b0;
        sink_wait <= next_wait - 1;
      end else begin
        dist_ch.ready <= 1'b1;
        sink_wait <= 0;
      end
    end
  end

  // stimulus sequence
  initial begin
    logic [2:0][pmid_pkg::SIDE_BITS-1:0] box;
    int                                  n_items;
    bit                                  spare;

    pair_ch.valid = 1'b0;
    pair_ch.func = 1'b0;
    pair_ch.first_x = '0;
    pair_ch.first_y = '0;
    pair_ch.first_z = '0;
    pair_ch.second_x = '0;
    pair_ch.second_y = '0;
    pair_ch.second_z = '0;
    dist_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = pmid_pkg::REG_SIDE_X;
    cfg_ch.data = '0;
    for (int d = 0; d < pmid_pkg::NUM_SIDES; d++) side_len[d] = pmid_pkg::SIDE_RESET;
    pairs_queued = 0;
    pairs_accepted = 0;
    error_count = 0;
    cycle_count = 0;
    steady_src = 1'b0;
    steady_sink = 1'b0;

    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, sides at their reset maximum
    queue_pair(make_pair(1'b0, 0, 0, 0, 0, 0, 0));
    queue_pair(make_pair(1'b1, 0, 0, 0, 0, 0, 0));
    // far apart across the box, folds to one unit each
    queue_pair(make_pair(1'b0, COORD_MAX - 1, COORD_MAX - 1, COORD_MAX - 1, 0, 0, 0));
    queue_pair(make_pair(1'b1, COORD_MAX - 1, COORD_MAX - 1, COORD_MAX - 1, 0, 0, 0));
    // just under half a side, no fold, largest squared sum
    queue_pair(make_pair(1'b0, 524287, 524287, 524287, 0, 0, 0));
    queue_pair(make_pair(1'b1, 524287, 524287, 524287, 0, 0, 0));
    // coordinate on the side itself
    queue_pair(make_pair(1'b0, COORD_MAX, 0, 0, 0, 0, 0));
    queue_pair(make_pair(1'b0, 0, 0, 0, 0, 0, COORD_MAX));
    queue_pair(make_pair(1'b1, COORD_MAX, COORD_MAX, COORD_MAX,
                         COORD_MAX, COORD_MAX, COORD_MAX));
    wait_drained();

    // directed, small sides with exact half-side ties and a unit side
    box = {20'd4096, 20'd1, 20'd1000};
    program_box(box, 1'b1);
    queue_pair(make_pair(1'b0, 0, 0, 0, 500, 0, 2048));
    queue_pair(make_pair(1'b1, 0, 0, 0, 500, 0, 2048));
    queue_pair(make_pair(1'b0, 999, 0, 4095, 0, 0, 1));
    queue_pair(make_pair(1'b1, 300, 0, 10, 900, 0, 4000));
    queue_pair(make_pair(1'b0, 300, 0, 0, 900, 1, 0));
    queue_pair(make_pair(1'b1, 0, 0, 4096, 0, 0, 0));

    // random phases over a range of box shapes
    for (int p = 0; p < 6; p++) begin
      spare = 1'b0;
      n_items = 80;
      case (p)
        0: begin
          box = {pmid_pkg::SIDE_RESET, pmid_pkg::SIDE_RESET, pmid_pkg::SIDE_RESET};
        end
        1: begin
          box = {pmid_pkg::SIDE_BITS'($urandom_range(1, pmid_pkg::SIDE_RESET)),
                 pmid_pkg::SIDE_BITS'($urandom_range(1, pmid_pkg::SIDE_RESET)),
                 pmid_pkg::SIDE_BITS'($urandom_range(1, pmid_pkg::SIDE_RESET))};
        end
        2: begin
          box = {pmid_pkg::SIDE_BITS'($urandom_range(1, 64)),
                 pmid_pkg::SIDE_BITS'($urandom_range(1, 64)),
                 pmid_pkg::SIDE_BITS'($urandom_range(1, 64))};
        end
        3: begin
          box = {pmid_pkg::SIDE_BITS'($urandom_range(1, 524287) * 2), pmid_pkg::SIDE_RESET,
                 pmid_pkg::SIDE_BITS'(1)};
          spare = 1'b1;
        end
        4: begin
          // zero sides leave every coordinate outside
          box = '0;
          n_items = 20;
          spare = 1'b1;
        end
        default: begin
          box = {pmid_pkg::SIDE_BITS'($urandom_range(1, pmid_pkg::SIDE_RESET)),
                 pmid_pkg::SIDE_BITS'($urandom_range(1, 4096)),
                 pmid_pkg::SIDE_BITS'($urandom_range(1, pmid_pkg::SIDE_RESET))};
          n_items = 100;
        end
      endcase
      wait_drained();
      program_box(box, spare);
      steady_src = (p == 1 || p == 5);
      steady_sink = (p == 2 || p == 5);
      for (int i = 0; i < n_items; i++) queue_pair(random_pair(box));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_dist_q.size() == 0) begin
      $display("tb_periodic_min_image_distance: PASS");
    end else begin
      $display("tb_periodic_min_image_distance: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/pmid_pkg.sv
sv/pmid_ifs.sv
sv/pmid_lane.sv
sv/pmid_root_cell.sv
sv/periodic_min_image_distance.sv
bench/tb_periodic_min_image_distance.sv
